// ----- sv/ftalloc_pkg.sv -----
`default_nettype none

package ftalloc_pkg;

    localparam int BLOCK_COUNT_DEF  = 128;
    localparam int NAME_BYTES_DEF   = 32;
    localparam int RESERVED_RESET   = 10;
    localparam int BLK_W            = 7;
    localparam int NAME_WORD_W      = 64;
    localparam int NAME_W           = 4 * NAME_WORD_W;

    typedef logic [2:0] opcode_t;
    typedef logic [2:0] status_t;

    localparam opcode_t OP_FORMAT = 3'd0;
    localparam opcode_t OP_CREATE = 3'd1;
    localparam opcode_t OP_LOOKUP = 3'd2;
    localparam opcode_t OP_DELETE = 3'd3;
    localparam opcode_t OP_PROBE  = 3'd4;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_NOT_FOUND = 3'd1;
    localparam status_t ST_EXISTS    = 3'd2;
    localparam status_t ST_NO_SPACE  = 3'd3;
    localparam status_t ST_INVALID   = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_PROBE,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [BLK_W-1:0]    block_number;
        logic                block_used;
        logic [NAME_W-1:0]   name;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/ftalloc_table.sv -----
`default_nettype none

module ftalloc_table #(
    parameter int DEPTH = ftalloc_pkg::BLOCK_COUNT_DEF,
    parameter int WIDTH = 8 * ftalloc_pkg::NAME_BYTES_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/ftalloc_ctrl.sv -----
`default_nettype none

module ftalloc_ctrl #(
    parameter int BLOCK_COUNT = ftalloc_pkg::BLOCK_COUNT_DEF,
    parameter int NAME_BYTES  = ftalloc_pkg::NAME_BYTES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [ftalloc_pkg::BLK_W-1:0]     reserved,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire ftalloc_pkg::opcode_t              req_opcode,
    input  wire logic [ftalloc_pkg::NAME_W-1:0]    req_name,
    input  wire logic [ftalloc_pkg::BLK_W-1:0]     req_probe_index,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output ftalloc_pkg::result_t                   res
);

    localparam int NAME_BITS = 8 * NAME_BYTES;
    localparam int ENTRY_W   = NAME_BITS + 1;
    localparam int IDX_W     = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CNT_W     = $clog2(BLOCK_COUNT + 1);
    localparam int PEXT_W    = (IDX_W > ftalloc_pkg::BLK_W) ? IDX_W : ftalloc_pkg::BLK_W;
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(BLOCK_COUNT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_COUNT - 1);

    ftalloc_pkg::state_t  state_reg, state_next;
    ftalloc_pkg::opcode_t op_reg, op_next;
    logic [NAME_BITS-1:0] name_reg, name_next;
    logic [ftalloc_pkg::BLK_W-1:0] pidx_reg, pidx_next;
    logic [CNT_W-1:0]     addr_reg, addr_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 fmt_pend_reg, fmt_pend_next;
    ftalloc_pkg::result_t res_reg, res_next;

    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    logic [ENTRY_W-1:0]   tbl_wdata;
    logic                 tbl_re;
    logic [IDX_W-1:0]     tbl_raddr;
    logic [ENTRY_W-1:0]   tbl_rdata;

    logic                 ent_occ;
    logic [NAME_BITS-1:0] ent_name;
    logic                 ent_match;
    logic [PEXT_W-1:0]    pidx_ext;
    logic                 pidx_in_range;
    logic                 probe_occ;
    logic [CNT_W-1:0]     scan_start;

    ftalloc_table #(
        .DEPTH (BLOCK_COUNT),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign ent_occ   = tbl_rdata[NAME_BITS];
    assign ent_name  = tbl_rdata[NAME_BITS-1:0];
    assign ent_match = chk_vld_reg && ent_occ && (ent_name == name_reg);
    assign pidx_ext  = PEXT_W'(req_probe_index);
    assign pidx_in_range = (32'(pidx_reg) < 32'(BLOCK_COUNT));
    assign probe_occ     = pidx_in_range && ent_occ;
    assign scan_start    = (32'(reserved) >= 32'(BLOCK_COUNT)) ? CNT_END : CNT_W'(reserved);

    assign req_ready = (state_reg == ftalloc_pkg::S_IDLE);
    assign res_valid = (state_reg == ftalloc_pkg::S_DONE);
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ftalloc_pkg::S_CLEAR;
            addr_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            fmt_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            chk_vld_reg  <= chk_vld_next;
            fmt_pend_reg <= fmt_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        name_reg       <= name_next;
        pidx_reg       <= pidx_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_reg        <= res_next;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        name_next       = name_reg;
        pidx_next       = pidx_reg;
        addr_next       = addr_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        fmt_pend_next   = fmt_pend_reg;
        res_next        = res_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = addr_reg[IDX_W-1:0];
        tbl_wdata       = '0;
        tbl_re          = 1'b0;
        tbl_raddr       = pidx_ext[IDX_W-1:0];

        unique case (state_reg)
            ftalloc_pkg::S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = addr_reg[IDX_W-1:0];
                addr_next = addr_reg + CNT_W'(1);
                if (addr_reg == CNT_LAST) begin
                    addr_next = '0;
                    if (fmt_pend_reg) begin
                        fmt_pend_next = 1'b0;
                        res_next      = '0;
                        state_next    = ftalloc_pkg::S_DONE;
                    end else begin
                        state_next = ftalloc_pkg::S_IDLE;
                    end
                end
            end

            ftalloc_pkg::S_IDLE: begin
                tbl_re = req_valid;
                if (req_valid) begin
                    op_next         = req_opcode;
                    name_next       = req_name[NAME_BITS-1:0];
                    pidx_next       = req_probe_index;
                    chk_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    addr_next       = scan_start;
                    res_next        = '0;
                    unique case (req_opcode) inside
                        ftalloc_pkg::OP_FORMAT: begin
                            addr_next     = '0;
                            fmt_pend_next = 1'b1;
                            state_next    = ftalloc_pkg::S_CLEAR;
                        end
                        ftalloc_pkg::OP_CREATE, ftalloc_pkg::OP_LOOKUP,
                        ftalloc_pkg::OP_DELETE: begin
                            state_next = ftalloc_pkg::S_SCAN;
                        end
                        ftalloc_pkg::OP_PROBE: begin
                            state_next = ftalloc_pkg::S_PROBE;
                        end
                        default: begin
                            res_next.status = ftalloc_pkg::ST_INVALID;
                            state_next      = ftalloc_pkg::S_DONE;
                        end
                    endcase
                end
            end

            ftalloc_pkg::S_SCAN: begin
                // read issue runs one entry ahead of the compare
                if (addr_reg < CNT_END) begin
                    tbl_re       = 1'b1;
                    tbl_raddr    = addr_reg[IDX_W-1:0];
                    addr_next    = addr_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = addr_reg[IDX_W-1:0];
                end else begin
                    chk_vld_next = 1'b0;
                end

                if (chk_vld_reg && !ent_occ && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end

                if (ent_match) begin
                    state_next = ftalloc_pkg::S_DONE;
                    if (op_reg == ftalloc_pkg::OP_CREATE) begin
                        res_next.status = ftalloc_pkg::ST_EXISTS;
                    end else begin
                        res_next.status       = ftalloc_pkg::ST_OK;
                        res_next.block_number = ftalloc_pkg::BLK_W'(chk_idx_reg);
                        if (op_reg == ftalloc_pkg::OP_DELETE) begin
                            tbl_we    = 1'b1;
                            tbl_waddr = chk_idx_reg;
                        end
                    end
                end else if (!chk_vld_reg && (addr_reg >= CNT_END)) begin
                    state_next = ftalloc_pkg::S_DONE;
                    if (op_reg != ftalloc_pkg::OP_CREATE) begin
                        res_next.status = ftalloc_pkg::ST_NOT_FOUND;
                    end else if (free_found_reg) begin
                        tbl_we                = 1'b1;
                        tbl_waddr             = free_idx_reg;
                        tbl_wdata             = {1'b1, name_reg};
                        res_next.status       = ftalloc_pkg::ST_OK;
                        res_next.block_number = ftalloc_pkg::BLK_W'(free_idx_reg);
                    end else begin
                        res_next.status = ftalloc_pkg::ST_NO_SPACE;
                    end
                end
            end

            ftalloc_pkg::S_PROBE: begin
                res_next.status       = ftalloc_pkg::ST_OK;
                res_next.block_number = pidx_reg;
                res_next.block_used   = probe_occ ||
                                        (pidx_in_range && (pidx_reg < reserved));
                res_next.name         = probe_occ ? ftalloc_pkg::NAME_W'(ent_name) : '0;
                state_next            = ftalloc_pkg::S_DONE;
            end

            ftalloc_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = ftalloc_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ftalloc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/file_name_table_allocator_top.sv -----
`default_nettype none

// Channel  | Handshake          | Payload
// input    | s_valid / s_ready  | s_opcode, s_name_word0..3, s_probe_index
// result   | m_valid / m_ready  | m_status, m_block_number, m_block_used,
//          |                    | m_out_name_word0..3
// config   | cfg_wr_en          | cfg_wr_data (reserved_block_count)
//
// Create, lookup and delete scan the entry RAM one block per cycle from the
// reserved boundary, stopping early on a name match. Probe reads one entry;
// format clears the RAM. After reset a clear pass over every entry runs
// before s_ready rises. A result waits in the output register; the next item
// is taken meanwhile and holds in its done state only while that register is
// still full.

module file_name_table_allocator_top #(
    parameter int BLOCK_COUNT = ftalloc_pkg::BLOCK_COUNT_DEF,
    parameter int NAME_BYTES  = ftalloc_pkg::NAME_BYTES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ftalloc_pkg::BLK_W-1:0]       cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [2:0]                          s_opcode,
    input  wire logic [ftalloc_pkg::NAME_WORD_W-1:0] s_name_word0,
    input  wire logic [ftalloc_pkg::NAME_WORD_W-1:0] s_name_word1,
    input  wire logic [ftalloc_pkg::NAME_WORD_W-1:0] s_name_word2,
    input  wire logic [ftalloc_pkg::NAME_WORD_W-1:0] s_name_word3,
    input  wire logic [ftalloc_pkg::BLK_W-1:0]       s_probe_index,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [2:0]                               m_status,
    output logic [ftalloc_pkg::BLK_W-1:0]            m_block_number,
    output logic                                     m_block_used,
    output logic [ftalloc_pkg::NAME_WORD_W-1:0]      m_out_name_word0,
    output logic [ftalloc_pkg::NAME_WORD_W-1:0]      m_out_name_word1,
    output logic [ftalloc_pkg::NAME_WORD_W-1:0]      m_out_name_word2,
    output logic [ftalloc_pkg::NAME_WORD_W-1:0]      m_out_name_word3
);

    localparam int WW = ftalloc_pkg::NAME_WORD_W;

    logic [ftalloc_pkg::BLK_W-1:0] reserved_reg, reserved_next;
    logic                          m_valid_reg, m_valid_next;
    ftalloc_pkg::result_t          m_res_reg, m_res_next;

    logic                          res_valid;
    logic                          res_ready;
    ftalloc_pkg::result_t          res;

    ftalloc_ctrl #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .NAME_BYTES  (NAME_BYTES)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .reserved        (reserved_reg),
        .req_valid       (s_valid),
        .req_ready       (s_ready),
        .req_opcode      (s_opcode),
        .req_name        ({s_name_word3, s_name_word2, s_name_word1, s_name_word0}),
        .req_probe_index (s_probe_index),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        reserved_next = cfg_wr_en ? cfg_wr_data : reserved_reg;
        m_valid_next  = m_valid_reg;
        m_res_next    = m_res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= ftalloc_pkg::BLK_W'(ftalloc_pkg::RESERVED_RESET);
            m_valid_reg  <= 1'b0;
        end else begin
            reserved_reg <= reserved_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_res_reg.status;
    assign m_block_number   = m_res_reg.block_number;
    assign m_block_used     = m_res_reg.block_used;
    assign m_out_name_word0 = m_res_reg.name[WW-1:0];
    assign m_out_name_word1 = m_res_reg.name[2*WW-1:WW];
    assign m_out_name_word2 = m_res_reg.name[3*WW-1:2*WW];
    assign m_out_name_word3 = m_res_reg.name[4*WW-1:3*WW];

endmodule

`default_nettype wire
